// ===== src/cfcr_pkg.sv =====
package cfcr_pkg;
    typedef enum logic [2:0] {
        REQ_BEGIN_WR = 3'd0,
        REQ_PAYLOAD  = 3'd1,
        REQ_BEGIN_RD = 3'd2,
        REQ_RX_BYTE  = 3'd3,
        REQ_TIMEOUT  = 3'd4
    } t_req;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_TEXT   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_CRC     = 3'd1;
    localparam logic [2:0] ST_BAD_ACK = 3'd2;
    localparam logic [2:0] ST_NO_TERM = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;
    localparam logic [2:0] ST_STRAY   = 3'd5;

    localparam logic [7:0] ACK_BYTE   = 8'hFF;
    localparam logic [7:0] ADDR_RESET = 8'd128;

    localparam logic [2:0] RK_TWO     = 3'd0;
    localparam logic [2:0] RK_FOUR    = 3'd1;
    localparam logic [2:0] RK_FIVE    = 3'd2;
    localparam logic [2:0] RK_SIXTEEN = 3'd3;
    localparam logic [2:0] RK_TEXT    = 3'd4;

    typedef enum logic [2:0] {
        DS_NONE    = 3'd0,
        DS_TX      = 3'd1,
        DS_STATUS  = 3'd2,
        DS_WORD    = 3'd3,
        DS_TEXT    = 3'd4
    } t_dsel;

    // controller -> datapath
    typedef struct packed {
        logic       crc_clear;
        logic       crc_feed;
        logic [7:0] crc_byte;
        logic       store_wr;
        logic [5:0] store_addr;
        logic [7:0] store_data;
        logic       rd_en;
        logic [5:0] rd_addr;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [15:0] crc;
        logic [7:0]  rd_data;
    } t_dp_sts;

    function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction
endpackage

// ===== src/cfcr_datapath.sv =====
module cfcr_datapath
    import cfcr_pkg::*;
#(
    parameter int DEPTH = 48
) (
    input  logic    i_clk,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts
);
    localparam int AW = $clog2(DEPTH);
    logic [7:0]  r_mem [DEPTH];
    logic [15:0] r_crc;
    logic [7:0]  r_rd;

    always_ff @(posedge i_clk) begin
        // restart from zero with the first byte of a frame
        if (i_cmd.crc_feed) begin
            r_crc <= crc_step(i_cmd.crc_clear ? 16'h0000 : r_crc, i_cmd.crc_byte);
        end else if (i_cmd.crc_clear) begin
            r_crc <= 16'h0000;
        end
        if (i_cmd.store_wr) begin
            r_mem[i_cmd.store_addr[AW-1:0]] <= i_cmd.store_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_cmd.rd_addr[AW-1:0]];
        end
    end

    assign o_sts.crc     = r_crc;
    assign o_sts.rd_data = r_rd;
endmodule

// ===== src/cfcr_ctrl.sv =====
module cfcr_ctrl
    import cfcr_pkg::*;
#(
    parameter int TEXT_MAX    = 48,
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req,
    input  logic [7:0]  i_cmd_code,
    input  logic [5:0]  i_len,
    input  logic [2:0]  i_rkind,
    input  logic [7:0]  i_byte,
    input  logic [7:0]  i_addr,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_byte,
    output logic [31:0] o_word,
    output logic [31:0] o_signed,
    output logic [2:0]  o_status,
    output logic        o_last,
    output t_dp_cmd     o_cmd,
    input  t_dp_sts     i_sts
);
    localparam logic [5:0] TMAX = 6'(TEXT_MAX);
    localparam logic [5:0] PMAX = 6'(MAX_PAYLOAD);

    typedef enum logic [3:0] {
        S_IDLE, S_EMIT, S_TX_CMD, S_TX_CRCH, S_TX_CRCL, S_RD_REQ, S_RD_WAIT,
        S_RD_GOT, S_WORD_OUT, S_FINAL
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE, PH_SEND, PH_ACK, PH_DATA, PH_CRCH, PH_CRCL
    } t_phase;

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [2:0]  r_ckind, n_ckind;
    logic [5:0]  r_cnt, r_exp, n_cnt, n_exp;
    logic [7:0]  r_crch, n_crch;
    logic [7:0]  r_cmd_hold, n_cmd_hold;
    logic [5:0]  r_ridx, n_ridx;
    logic [5:0]  r_rend, n_rend;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_bnum, n_bnum;
    logic [2:0]  r_fin_status, n_fin_status;
    logic        r_tx_crc, n_tx_crc;
    logic        r_ov, n_ov;
    logic [1:0]  r_ok, n_ok;
    logic [7:0]  r_ob, n_ob;
    logic [31:0] r_ow, r_os, n_ow, n_os;
    logic [2:0]  r_ost, n_ost;
    logic        r_ol, n_ol;
    logic [7:0]  r_nb, n_nb;
    logic [5:0]  w_cnt_inc;
    logic [2:0]  w_rkind;

    wire out_free = !r_ov || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE) && !r_ov;
    assign o_out_valid = r_ov;
    assign o_kind      = r_ok;
    assign o_byte      = r_ob;
    assign o_word      = r_ow;
    assign o_signed    = r_os;
    assign o_status    = r_ost;
    assign o_last      = r_ol;

    wire in_go = i_in_valid && o_in_ready;

    assign w_cnt_inc = r_cnt + 6'd1;
    assign w_rkind   = (i_rkind > RK_TEXT) ? RK_TEXT : i_rkind;

    always_comb begin
        o_cmd = '0;
        if (in_go) begin
            unique case (i_req)
                REQ_BEGIN_WR, REQ_BEGIN_RD: begin
                    o_cmd.crc_feed = 1'b1;
                    o_cmd.crc_clear = 1'b1;
                    o_cmd.crc_byte = i_addr;
                end
                REQ_PAYLOAD: begin
                    if (r_phase == PH_SEND && r_cnt < r_exp) begin
                        o_cmd.crc_feed = 1'b1;
                        o_cmd.crc_byte = i_byte;
                    end
                end
                REQ_RX_BYTE: begin
                    if (r_phase == PH_DATA) begin
                        o_cmd.crc_feed = 1'b1;
                        o_cmd.crc_byte = i_byte;
                        o_cmd.store_wr = (r_cnt < TMAX);
                        o_cmd.store_addr = r_cnt;
                        o_cmd.store_data = i_byte;
                    end
                end
                default: ;
            endcase
        end
        if (r_state == S_TX_CMD && out_free) begin
            o_cmd.crc_feed = 1'b1;
            o_cmd.crc_byte = r_cmd_hold;
        end
        if (r_state == S_RD_REQ) begin
            o_cmd.rd_en = 1'b1;
            o_cmd.rd_addr = r_ridx;
        end
    end

    // Each output beat is loaded into the output register as out_free allows.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_ckind = r_ckind;
        n_cnt = r_cnt;
        n_exp = r_exp;
        n_crch = r_crch;
        n_cmd_hold = r_cmd_hold;
        n_ridx = r_ridx;
        n_rend = r_rend;
        n_acc = r_acc;
        n_bnum = r_bnum;
        n_fin_status = r_fin_status;
        n_tx_crc = r_tx_crc;
        n_ov = r_ov;
        n_ok = r_ok;
        n_ob = r_ob;
        n_ow = r_ow;
        n_os = r_os;
        n_ost = r_ost;
        n_ol = r_ol;
        n_nb = r_nb;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_go) begin
                    n_ok = KIND_STATUS; n_ob = '0; n_ow = '0; n_os = '0;
                    n_ol = 1'b1; n_ost = ST_STRAY;
                    n_tx_crc = 1'b0;
                    priority if (i_req == REQ_BEGIN_WR || i_req == REQ_BEGIN_RD) begin
                        n_cmd_hold = i_cmd_code;
                        n_cnt = '0;
                        n_ok = KIND_TX; n_ob = i_addr; n_ol = 1'b0; n_ost = ST_OK;
                        n_ov = 1'b1;
                        n_state = S_TX_CMD;
                        if (i_req == REQ_BEGIN_WR) begin
                            n_exp = (i_len > PMAX) ? PMAX : i_len;
                            n_ckind = RK_TWO;
                            n_phase = PH_SEND;
                            n_tx_crc = (i_len == 6'd0);
                        end else begin
                            n_ckind = w_rkind;
                            unique case (w_rkind)
                                RK_TWO:     n_exp = 6'd2;
                                RK_FOUR:    n_exp = 6'd4;
                                RK_FIVE:    n_exp = 6'd5;
                                RK_SIXTEEN: n_exp = 6'd16;
                                default:    n_exp = TMAX;
                            endcase
                            n_phase = PH_DATA;
                        end
                    end else if (i_req == REQ_PAYLOAD && r_phase == PH_SEND
                                 && r_cnt < r_exp) begin
                        n_ok = KIND_TX; n_ob = i_byte; n_ost = ST_OK;
                        n_cnt = w_cnt_inc;
                        n_ov = 1'b1;
                        if (w_cnt_inc >= r_exp) begin
                            n_ol = 1'b0;
                            n_state = S_TX_CRCH;
                        end
                    end else if (i_req == REQ_RX_BYTE && r_phase == PH_ACK) begin
                        n_ost = (i_byte == ACK_BYTE) ? ST_OK : ST_BAD_ACK;
                        n_ov = 1'b1;
                        n_phase = PH_IDLE;
                    end else if (i_req == REQ_RX_BYTE && r_phase == PH_DATA) begin
                        n_cnt = w_cnt_inc;
                        if (r_ckind == RK_TEXT) begin
                            if (i_byte == 8'd0) n_phase = PH_CRCH;
                            else if (w_cnt_inc >= TMAX) begin
                                n_ost = ST_NO_TERM; n_ov = 1'b1; n_phase = PH_IDLE;
                            end
                        end else if (w_cnt_inc >= r_exp) n_phase = PH_CRCH;
                    end else if (i_req == REQ_RX_BYTE && r_phase == PH_CRCH) begin
                        n_crch = i_byte;
                        n_phase = PH_CRCL;
                    end else if (i_req == REQ_RX_BYTE && r_phase == PH_CRCL) begin
                        n_phase = PH_IDLE;
                        if ({r_crch, i_byte} != i_sts.crc) begin
                            n_ost = ST_CRC; n_ov = 1'b1;
                        end else begin
                            n_fin_status = ST_OK;
                            n_ridx = '0;
                            n_bnum = '0;
                            n_acc = '0;
                            n_rend = (r_ckind == RK_TEXT) ?
                                     ((r_cnt < TMAX) ? r_cnt : TMAX) :
                                     (r_ckind == RK_TWO ? 6'd2 :
                                      r_ckind == RK_FOUR ? 6'd4 :
                                      r_ckind == RK_FIVE ? 6'd5 : 6'd16);
                            n_state = S_RD_REQ;
                        end
                    end else if (i_req == REQ_TIMEOUT && r_phase != PH_IDLE) begin
                        n_ost = ST_TIMEOUT; n_ov = 1'b1; n_phase = PH_IDLE;
                    end else begin
                        n_ov = 1'b1;
                    end
                end
            end
            S_TX_CMD: if (out_free) begin
                n_ok = KIND_TX; n_ob = r_cmd_hold; n_ov = 1'b1;
                n_ol = !(r_tx_crc || (r_phase == PH_SEND && r_exp == 6'd0));
                n_state = (r_phase == PH_SEND && r_exp == 6'd0) ? S_TX_CRCH : S_IDLE;
            end
            S_TX_CRCH: if (out_free) begin
                n_ok = KIND_TX; n_ob = i_sts.crc[15:8]; n_ol = 1'b0; n_ov = 1'b1;
                n_nb = i_sts.crc[7:0];
                n_state = S_TX_CRCL;
            end
            S_TX_CRCL: if (out_free) begin
                n_ok = KIND_TX; n_ob = r_nb; n_ol = 1'b1; n_ov = 1'b1;
                n_phase = PH_ACK;
                n_state = S_IDLE;
            end
            S_RD_REQ: begin
                if (r_ridx >= r_rend) n_state = S_FINAL;
                else n_state = S_RD_WAIT;
            end
            S_RD_WAIT: n_state = S_RD_GOT;
            S_RD_GOT: begin
                if (r_ckind == RK_TEXT) begin
                    if (i_sts.rd_data == 8'd0) n_state = S_FINAL;
                    else if (out_free) begin
                        n_ok = KIND_TEXT; n_ob = i_sts.rd_data; n_ow = '0;
                        n_os = '0; n_ost = ST_OK; n_ol = 1'b0; n_ov = 1'b1;
                        n_ridx = r_ridx + 6'd1;
                        n_state = S_RD_REQ;
                    end
                end else if (r_ckind == RK_FIVE && r_ridx == 6'd4) begin
                    n_nb = i_sts.rd_data;
                    n_ridx = r_ridx + 6'd1;
                    n_state = S_WORD_OUT;
                end else begin
                    n_acc = {r_acc[23:0], i_sts.rd_data};
                    n_ridx = r_ridx + 6'd1;
                    n_bnum = r_bnum + 3'd1;
                    if ((r_ckind == RK_TWO && r_bnum == 3'd1) ||
                        (r_ckind == RK_FOUR && r_bnum == 3'd3) ||
                        (r_ckind == RK_SIXTEEN && r_bnum == 3'd3)) begin
                        n_state = S_WORD_OUT;
                    end else n_state = S_RD_REQ;
                end
            end
            S_WORD_OUT: if (out_free) begin
                n_ok = KIND_WORD; n_ost = ST_OK; n_ol = 1'b0; n_ov = 1'b1;
                n_ow = r_acc;
                if (r_ckind == RK_FIVE) begin
                    n_ob = r_nb;
                    n_os = (r_nb != 8'd0) ? (32'd0 - r_acc) : r_acc;
                    n_state = S_FINAL;
                end else begin
                    n_ob = '0;
                    n_os = r_acc;
                    n_bnum = '0;
                    n_state = S_RD_REQ;
                end
            end
            S_FINAL: if (out_free) begin
                n_ok = KIND_STATUS; n_ob = '0; n_ow = '0; n_os = '0;
                n_ost = r_fin_status; n_ol = 1'b1; n_ov = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
            r_ckind <= '0;
            r_cnt <= '0;
            r_exp <= '0;
            r_crch <= '0;
            r_cmd_hold <= '0;
            r_ridx <= '0;
            r_rend <= '0;
            r_acc <= '0;
            r_bnum <= '0;
            r_fin_status <= '0;
            r_tx_crc <= 1'b0;
            r_ov <= 1'b0;
            r_ok <= '0;
            r_ob <= '0;
            r_ow <= '0;
            r_os <= '0;
            r_ost <= '0;
            r_ol <= 1'b0;
            r_nb <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_ckind <= n_ckind;
            r_cnt <= n_cnt;
            r_exp <= n_exp;
            r_crch <= n_crch;
            r_cmd_hold <= n_cmd_hold;
            r_ridx <= n_ridx;
            r_rend <= n_rend;
            r_acc <= n_acc;
            r_bnum <= n_bnum;
            r_fin_status <= n_fin_status;
            r_tx_crc <= n_tx_crc;
            r_ov <= n_ov;
            r_ok <= n_ok;
            r_ob <= n_ob;
            r_ow <= n_ow;
            r_os <= n_os;
            r_ost <= n_ost;
            r_ol <= n_ol;
            r_nb <= n_nb;
        end
    end
endmodule

// ===== src/crc_framed_command_reply_engine_unit.sv =====
// CRC-16 (0x1021, init 0) command/reply host engine. One input beat is taken
// at a time, only while the engine idles and its output register is empty. A
// begin emits the address and then the command byte; an empty write also emits
// the two CRC bytes, and so does the last payload byte after itself. A good reply
// replays the 48-entry byte store through its registered read port, each byte
// passing S_RD_REQ, S_RD_WAIT and S_RD_GOT. Sink stalls hold the output beat and
// the beat-emitting states. device_address is at byte address 0.
module crc_framed_command_reply_engine_unit
    import cfcr_pkg::*;
#(
    parameter int TEXT_MAX    = 48,
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[7:0], length[5:0], reply_kind[2:0], data_byte[7:0] low first
    input  logic [31:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte[7:0], out_word[31:0], out_signed[31:0], out_status[2:0] low first
    output logic [79:0] m_axis_tdata,
    // out_kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [7:0]  r_addr;
    t_dp_cmd     w_cmd;
    t_dp_sts     w_sts;
    logic [7:0]  w_b;
    logic [31:0] w_w, w_s;
    logic [2:0]  w_st;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {24'd0, r_addr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_addr <= ADDR_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0) r_addr <= pwdata[7:0];
    end

    cfcr_ctrl #(.TEXT_MAX(TEXT_MAX), .MAX_PAYLOAD(MAX_PAYLOAD)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_req(s_axis_tuser), .i_cmd_code(s_axis_tdata[7:0]),
        .i_len(s_axis_tdata[13:8]), .i_rkind(s_axis_tdata[16:14]),
        .i_byte(s_axis_tdata[24:17]), .i_addr(r_addr),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_kind(m_axis_tuser), .o_byte(w_b), .o_word(w_w), .o_signed(w_s),
        .o_status(w_st), .o_last(m_axis_tlast),
        .o_cmd(w_cmd), .i_sts(w_sts)
    );

    cfcr_datapath #(.DEPTH(TEXT_MAX)) u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .o_sts(w_sts)
    );

    assign m_axis_tdata = {5'd0, w_st, w_s, w_w, w_b};
endmodule

// ===== src/cfcr_checker.sv =====
module cfcr_sva
    import cfcr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken with output pending");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_STATUS |-> m_axis_tlast)
        else $error("status beat not last");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind crc_framed_command_reply_engine_unit cfcr_sva u_chk (.*);

// ===== dv/cfcr_checker.sv =====
`timescale 1ns / 1ps
module cfcr_checker
    import cfcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_data,
    input  logic [2:0]  s_user,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [79:0] m_data,
    input  logic [1:0]  m_user,
    input  logic        m_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending
);
    localparam int TEXT_MAX    = 48;
    localparam int MAX_PAYLOAD = 32;

    typedef enum logic [2:0] {
        LK_IDLE, LK_SEND, LK_ACK, LK_DATA, LK_CRCH, LK_CRCL
    } t_link;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  bval;
        logic [31:0] word;
        logic [31:0] sgn;
        logic [2:0]  status;
        logic        last;
    } t_reply;

    t_reply      reply_q[$];
    logic [7:0]  dev_addr;
    t_link       link;
    logic [15:0] crc_acc;
    logic [2:0]  kind_r;
    logic [5:0]  rx_cnt;
    logic [5:0]  want_cnt;
    logic [7:0]  crc_hi;
    logic [7:0]  store [TEXT_MAX];

    function automatic logic [15:0] crc_next(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        repeat (8) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    function void push(input logic [1:0] k, input logic [7:0] bv, input logic [31:0] w,
                       input logic [31:0] s, input logic [2:0] st);
        t_reply r;
        r.kind = k; r.bval = bv; r.word = w; r.sgn = s; r.status = st; r.last = 1'b0;
        reply_q = {reply_q, r};
    endfunction

    function void tx(input logic [7:0] b);
        push(KIND_TX, b, '0, '0, ST_OK);
        crc_acc = crc_next(crc_acc, b);
    endfunction

    function logic [31:0] word_at(input int i);
        return {store[i], store[i+1], store[i+2], store[i+3]};
    endfunction

    function void replay();
        logic [31:0] w;
        case (kind_r)
            RK_TWO: begin
                w = {16'h0, store[0], store[1]};
                push(KIND_WORD, '0, w, w, ST_OK);
            end
            RK_FOUR: begin
                w = word_at(0);
                push(KIND_WORD, '0, w, w, ST_OK);
            end
            RK_FIVE: begin
                w = word_at(0);
                push(KIND_WORD, store[4], w, (store[4] != 8'd0) ? (32'd0 - w) : w, ST_OK);
            end
            RK_SIXTEEN: begin
                for (int i = 0; i < 4; i++) begin
                    w = word_at(4 * i);
                    push(KIND_WORD, '0, w, w, ST_OK);
                end
            end
            default: begin
                for (int i = 0; i < rx_cnt && i < TEXT_MAX; i++) begin
                    if (store[i] == 8'd0) break;
                    push(KIND_TEXT, store[i], '0, '0, ST_OK);
                end
            end
        endcase
    endfunction

    function void predict(input logic [2:0] req, input logic [31:0] d);
        logic [7:0] cmd;
        logic [5:0] len;
        logic [2:0] rk;
        logic [7:0] b;
        int         before_n;
        cmd = d[7:0]; len = d[13:8]; rk = d[16:14]; b = d[24:17];
        before_n = reply_q.size();
        if (req == REQ_BEGIN_WR || req == REQ_BEGIN_RD) begin
            crc_acc = '0;
            rx_cnt = '0;
            tx(dev_addr);
            tx(cmd);
            if (req == REQ_BEGIN_WR) begin
                want_cnt = (len > MAX_PAYLOAD) ? 6'(MAX_PAYLOAD) : len;
                kind_r = RK_TWO;
                link = LK_SEND;
            end else begin
                if (rk > RK_TEXT) rk = RK_TEXT;
                kind_r = rk;
                case (rk)
                    RK_TWO:     want_cnt = 6'd2;
                    RK_FOUR:    want_cnt = 6'd4;
                    RK_FIVE:    want_cnt = 6'd5;
                    RK_SIXTEEN: want_cnt = 6'd16;
                    default:    want_cnt = 6'(TEXT_MAX);
                endcase
                link = LK_DATA;
            end
        end else if (req == REQ_PAYLOAD && link == LK_SEND && rx_cnt < want_cnt) begin
            tx(b);
            rx_cnt++;
        end else if (req == REQ_RX_BYTE && link == LK_ACK) begin
            push(KIND_STATUS, '0, '0, '0, (b == ACK_BYTE) ? ST_OK : ST_BAD_ACK);
            link = LK_IDLE;
        end else if (req == REQ_RX_BYTE && link == LK_DATA) begin
            if (rx_cnt < TEXT_MAX) store[rx_cnt] = b;
            crc_acc = crc_next(crc_acc, b);
            rx_cnt++;
            if (kind_r == RK_TEXT) begin
                if (b == 8'd0) link = LK_CRCH;
                else if (rx_cnt >= TEXT_MAX) begin
                    push(KIND_STATUS, '0, '0, '0, ST_NO_TERM);
                    link = LK_IDLE;
                end
            end else if (rx_cnt >= want_cnt) link = LK_CRCH;
        end else if (req == REQ_RX_BYTE && link == LK_CRCH) begin
            crc_hi = b;
            link = LK_CRCL;
        end else if (req == REQ_RX_BYTE && link == LK_CRCL) begin
            if ({crc_hi, b} != crc_acc) push(KIND_STATUS, '0, '0, '0, ST_CRC);
            else begin
                replay();
                push(KIND_STATUS, '0, '0, '0, ST_OK);
            end
            link = LK_IDLE;
        end else if (req == REQ_TIMEOUT && link != LK_IDLE) begin
            push(KIND_STATUS, '0, '0, '0, ST_TIMEOUT);
            link = LK_IDLE;
        end else begin
            push(KIND_STATUS, '0, '0, '0, ST_STRAY);
        end
        if (link == LK_SEND && rx_cnt >= want_cnt) begin
            push(KIND_TX, crc_acc[15:8], '0, '0, ST_OK);
            push(KIND_TX, crc_acc[7:0], '0, '0, ST_OK);
            link = LK_ACK;
        end
        if (reply_q.size() > before_n) reply_q[$].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_reply e;
        if (!i_rst_n) begin
            dev_addr <= ADDR_RESET;
            link = LK_IDLE;
            crc_acc = '0;
            kind_r = '0;
            rx_cnt = '0;
            want_cnt = '0;
            crc_hi = '0;
            fail_count = 0;
            pending = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == 2'd0)
                dev_addr <= pwdata[7:0];
            if (s_valid && s_ready)
                predict(s_user, s_data);
            if (m_valid && m_ready) begin
                if (reply_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected beat kind=%0d data=%h last=%b",
                                 m_user, m_data, m_last);
                end else begin
                    e = reply_q.pop_front();
                    if (m_user !== e.kind || m_data[7:0] !== e.bval
                        || m_data[39:8] !== e.word || m_data[71:40] !== e.sgn
                        || m_data[74:72] !== e.status || m_last !== e.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"ERROR: exp kind=%0d byte=%h word=%h sgn=%h st=%0d ",
                                      "last=%b got kind=%0d byte=%h word=%h sgn=%h st=%0d last=%b"},
                                     e.kind, e.bval, e.word, e.sgn, e.status, e.last,
                                     m_user, m_data[7:0], m_data[39:8], m_data[71:40],
                                     m_data[74:72], m_last);
                    end
                end
            end
            pending = reply_q.size();
        end
    end
endmodule

// ===== dv/crc_framed_command_reply_engine_unit_tb.sv =====
`timescale 1ns / 1ps
module crc_framed_command_reply_engine_unit_tb;
    import cfcr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN       = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          beats_sent = 0;
    logic [7:0]  dev_addr = ADDR_RESET;

    crc_framed_command_reply_engine_unit uut (.*);

    cfcr_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
        .s_data(s_axis_tdata), .s_user(s_axis_tuser),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .m_data(m_axis_tdata), .m_user(m_axis_tuser), .m_last(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // valid stays up after the accepting edge; the next put replaces the beat or drops it, settle drops it
    task automatic put(input logic [2:0] req, input logic [7:0] cmd, input logic [5:0] len,
                       input logic [2:0] rk, input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {7'h0, b, rk, len, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    task automatic rx(input logic [7:0] b);
        put(REQ_RX_BYTE, 8'($urandom), 6'($urandom), 3'($urandom), b);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_addr(input logic [7:0] a);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= {24'h0, a};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        dev_addr = a;
    endtask

    // abort: -1 none, else drop the transfer with a timeout after that many payload beats
    task automatic write_frame(input logic [7:0] cmd, input logic [5:0] len,
                               input logic [7:0] ack, input int abort);
        int n;
        n = (len > 32) ? 32 : len;
        put(REQ_BEGIN_WR, cmd, len, 3'($urandom), 8'($urandom));
        for (int i = 0; i < n; i++) begin
            if (i == abort) begin
                put(REQ_TIMEOUT, 8'($urandom), 6'($urandom), 3'($urandom), 8'($urandom));
                return;
            end
            put(REQ_PAYLOAD, 8'($urandom), 6'($urandom), 3'($urandom), 8'($urandom));
        end
        rx(ack);
    endtask

    // text_len: nonzero chars before the terminator; 48 means none arrives
    task automatic read_frame(input logic [7:0] cmd, input logic [2:0] rk, input int text_len,
                              input bit bad_crc, input int abort);
        logic [15:0] c;
        logic [7:0]  b;
        int          n;
        c = crc_step(crc_step(16'h0, dev_addr), cmd);
        case (rk)
            RK_TWO:     n = 2;
            RK_FOUR:    n = 4;
            RK_FIVE:    n = 5;
            RK_SIXTEEN: n = 16;
            default:    n = (text_len >= 48) ? 48 : text_len + 1;
        endcase
        put(REQ_BEGIN_RD, cmd, 6'($urandom), rk, 8'($urandom));
        for (int i = 0; i < n; i++) begin
            if (i == abort) begin
                put(REQ_TIMEOUT, 8'($urandom), 6'($urandom), 3'($urandom), 8'($urandom));
                return;
            end
            if (rk >= RK_TEXT) b = (i < text_len) ? 8'($urandom_range(1, 255)) : 8'h00;
            else if (rk == RK_FIVE && i == 4 && $urandom_range(0, 1)) b = 8'h00;
            else b = 8'($urandom);
            c = crc_step(c, b);
            rx(b);
        end
        if (rk >= RK_TEXT && text_len >= 48) return;
        if (abort == n) begin
            rx(c[15:8]);
            put(REQ_TIMEOUT, 8'($urandom), 6'($urandom), 3'($urandom), 8'($urandom));
            return;
        end
        rx(c[15:8]);
        rx(bad_crc ? c[7:0] ^ 8'($urandom_range(1, 255)) : c[7:0]);
    endtask

    task automatic random_run(input int target);
        int r;
        int lim;
        int tl;
        lim = beats_sent + target;
        while (beats_sent < lim) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                write_frame(8'($urandom),
                            ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 8)),
                            ($urandom_range(0, 9) < 7) ? ACK_BYTE : 8'($urandom),
                            ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : -1);
            end else if (r < 80) begin
                tl = ($urandom_range(0, 19) == 0) ? 48 : $urandom_range(0, 6);
                read_frame(8'($urandom), 3'($urandom_range(0, 7)), tl,
                           $urandom_range(0, 6) == 0,
                           ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : -1);
            end else begin
                put(3'($urandom), 8'($urandom), 6'($urandom), 3'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_addr(8'($urandom));
        tx_idle_pct = 32;
        rx_idle_pct = 60;
        write_frame(8'h00, 6'd0, ACK_BYTE, -1);
        write_frame(8'hFF, 6'd63, 8'h00, 2);
        write_frame(8'h5A, 6'd2, ACK_BYTE, -1);
        put(REQ_BEGIN_WR, 8'h11, 6'd1, 3'd0, 8'h00);
        rx(8'hAA);
        put(REQ_PAYLOAD, 8'h0, 6'd0, 3'd0, 8'hFF);
        put(REQ_PAYLOAD, 8'h0, 6'd0, 3'd0, 8'h01);
        rx(8'hFE);
        rx(8'h12);
        put(REQ_TIMEOUT, 8'h0, 6'd0, 3'd0, 8'h00);
        put(3'd5, 8'hFF, 6'd63, 3'd7, 8'hFF);
        put(3'd7, 8'h00, 6'd0, 3'd0, 8'h00);
        for (int k = 0; k < 5; k++) read_frame(8'($urandom), 3'(k), 3, 1'b0, -1);
        read_frame(8'h42, 3'd6, 0, 1'b0, -1);
        read_frame(8'h43, RK_SIXTEEN, 0, 1'b1, -1);
        put(REQ_BEGIN_RD, 8'h44, 6'd0, RK_FOUR, 8'h00);
        read_frame(8'h45, RK_TEXT, 48, 1'b0, -1);
        read_frame(8'h46, RK_TEXT, 47, 1'b0, -1);
        read_frame(8'h47, RK_FIVE, 0, 1'b0, 5);
        random_run(130);
        settle();

        set_addr(8'h00);
        tx_idle_pct = 60;
        rx_idle_pct = 32;
        random_run(130);
        settle();

        set_addr(8'hFF);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_run(130);
        settle();

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
